### rtl/obs_pkg.sv
// ----------------------------------------------------------------------------
// obs_pkg: shared types and constants for the overtake behavior supervisor
// Mode, side and reason codes, speed scales and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package obs_pkg;

  localparam int TS_W   = 32;
  localparam int DIST_W = 20;
  localparam int POS_W  = 21;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [TS_W-1:0] LOST_TIMEOUT_MS = 32'd500;

  localparam logic [15:0] CRUISE_SCALE = 16'd32768;
  localparam logic [15:0] TRAIL_SCALE  = 16'd24576;
  localparam logic [15:0] PASS_SCALE   = 16'd32768;
  localparam logic [15:0] RETURN_SCALE = 16'd29491;

  // Mode register, one-hot internally
  typedef enum logic [5:0] {
    MODE_INIT   = 6'b000001,
    MODE_TRACK  = 6'b000010,
    MODE_TRAIL  = 6'b000100,
    MODE_PASS   = 6'b001000,
    MODE_RETURN = 6'b010000,
    MODE_FAULT  = 6'b100000
  } mode_t;

  // Mode codes as seen on the output port
  localparam logic [2:0] MODE_CODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_CODE_TRACK  = 3'd1;
  localparam logic [2:0] MODE_CODE_TRAIL  = 3'd2;
  localparam logic [2:0] MODE_CODE_PASS   = 3'd3;
  localparam logic [2:0] MODE_CODE_RETURN = 3'd4;
  localparam logic [2:0] MODE_CODE_FAULT  = 3'd5;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_t;

  typedef enum logic [3:0] {
    RSN_NONE            = 4'd0,
    RSN_INVALID_TRAJ    = 4'd1,
    RSN_STALE_INPUT     = 4'd2,
    RSN_WAIT_INPUTS     = 4'd3,
    RSN_WAIT_TRAJ       = 4'd4,
    RSN_INIT_TRAJ_BAD   = 4'd5,
    RSN_INPUTS_READY    = 4'd6,
    RSN_OPP_AHEAD       = 4'd7,
    RSN_PATH_CLEAR      = 4'd8,
    RSN_SAFE_LEFT       = 4'd9,
    RSN_SAFE_RIGHT      = 4'd10,
    RSN_OPP_BEHIND      = 4'd11,
    RSN_OPP_LOST        = 4'd12,
    RSN_RACELINE        = 4'd13,
    RSN_FAULT_RECOVERED = 4'd14
  } reason_t;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_DIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORRIDOR_HALF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEHIND_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERTAKE_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETURN_THR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_CONFIRM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DWELL     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOV_CONFIRM = 3'd7;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    unique case (m)
      MODE_INIT:   c = MODE_CODE_INIT;
      MODE_TRACK:  c = MODE_CODE_TRACK;
      MODE_TRAIL:  c = MODE_CODE_TRAIL;
      MODE_PASS:   c = MODE_CODE_PASS;
      MODE_RETURN: c = MODE_CODE_RETURN;
      MODE_FAULT:  c = MODE_CODE_FAULT;
      default:     c = MODE_CODE_INIT;
    endcase
    return c;
  endfunction

  // Magnitude of a signed position; most negative value maps to 2^20
  function automatic logic [POS_W-1:0] pos_mag(input logic [POS_W-1:0] v);
    return v[POS_W-1] ? (~v + POS_W'(1)) : v;
  endfunction

endpackage

`default_nettype wire

### rtl/overtake_behavior_supervisor_unit.sv
// ----------------------------------------------------------------------------
// overtake_behavior_supervisor_unit: mode supervisor for overtaking
// Confirms mode changes over time, tracks opponent and validity, and emits
// one command beat per observation beat.
// ----------------------------------------------------------------------------
// Path: an accepted input is held in the input register, then passes decision
//   logic into the output register; a command channel stall holds it between.
// Throughput: one observation per cycle unless the command channel stalls.
// Reset: synchronous, active high; clears mode to init, all timers and the
//   pending move, and loads the configuration registers with their defaults.
`default_nettype none

module overtake_behavior_supervisor_unit
  import obs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // observation channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [TS_W-1:0]      timestamp,
  input  wire logic                 opponent_seen,
  input  wire logic [POS_W-1:0]     opponent_ahead_mm,
  input  wire logic [POS_W-1:0]     opponent_side_mm,
  input  wire logic [POS_W-1:0]     chosen_offset_mm,
  input  wire logic                 inputs_ok,
  input  wire logic                 path_ok,
  // command channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                mode_out,
  output logic [1:0]                side_out,
  output logic [3:0]                reason_out,
  output logic [15:0]               speed_factor,
  output logic                      use_local_path,
  output logic                      use_fallback,
  output logic                      time_error
);

  // configuration registers
  logic [DIST_W-1:0] follow_range;
  logic [DIST_W-1:0] corridor_half_width;
  logic [DIST_W-1:0] behind_margin;
  logic [DIST_W-1:0] overtake_threshold;
  logic [DIST_W-1:0] return_threshold;
  logic [TS_W-1:0]   transition_confirm_ms;
  logic [TS_W-1:0]   min_dwell_ms;
  logic [TS_W-1:0]   recovery_confirm_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      follow_range          <= DIST_W'(10000);
      corridor_half_width   <= DIST_W'(1000);
      behind_margin         <= DIST_W'(1000);
      overtake_threshold    <= DIST_W'(500);
      return_threshold      <= DIST_W'(200);
      transition_confirm_ms <= TS_W'(200);
      min_dwell_ms          <= TS_W'(500);
      recovery_confirm_ms   <= TS_W'(500);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FOLLOW_DIST:   follow_range          <= cfg_data[DIST_W-1:0];
        CFG_CORRIDOR_HALF: corridor_half_width   <= cfg_data[DIST_W-1:0];
        CFG_BEHIND_MARGIN: behind_margin         <= cfg_data[DIST_W-1:0];
        CFG_OVERTAKE_THR:  overtake_threshold    <= cfg_data[DIST_W-1:0];
        CFG_RETURN_THR:    return_threshold      <= cfg_data[DIST_W-1:0];
        CFG_TRANS_CONFIRM: transition_confirm_ms <= cfg_data;
        CFG_MIN_DWELL:     min_dwell_ms          <= cfg_data;
        CFG_RECOV_CONFIRM: recovery_confirm_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  logic             s1_valid;
  logic [TS_W-1:0]  s1_ts;
  logic             s1_seen;
  logic [POS_W-1:0] s1_lon;
  logic [POS_W-1:0] s1_lat;
  logic [POS_W-1:0] s1_sel;
  logic             s1_iok;
  logic             s1_pok;

  logic in_fire;
  logic advance;
  logic proc;

  assign advance  = !out_valid || out_ready;
  assign proc     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ts   <= timestamp;
      s1_seen <= opponent_seen;
      s1_lon  <= opponent_ahead_mm;
      s1_lat  <= opponent_side_mm;
      s1_sel  <= chosen_offset_mm;
      s1_iok  <= inputs_ok;
      s1_pok  <= path_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // supervisor state
  mode_t           mode,            mode_next;
  side_t           side,            side_next;
  reason_t         reason,          reason_next;
  logic            started,         started_next;
  logic [TS_W-1:0] previous_time,   previous_time_next;
  logic [TS_W-1:0] mode_entry_time, mode_entry_time_next;
  logic [TS_W-1:0] opp_last_time,   opp_last_time_next;
  logic            pending_valid,   pending_valid_next;
  reason_t         pending_reason,  pending_reason_next;
  logic [TS_W-1:0] pending_start,   pending_start_next;

  logic            terr;
  logic [TS_W-1:0] entry_eff;
  logic [TS_W-1:0] opp_eff;
  logic            dwell_ok;
  logic            ahead;
  logic            passed;
  logic            lost;
  logic [POS_W-1:0] lat_mag;
  logic [POS_W-1:0] sel_mag;
  logic [POS_W:0]  lon_plus_margin;
  logic            hold_req;
  reason_t         hold_why;
  logic [TS_W-1:0] hold_need;
  mode_t           go_mode;
  side_t           go_side;
  logic            same_pend;
  logic            hold_done;

  assign terr      = started && (s1_ts < previous_time);
  assign entry_eff = started ? mode_entry_time : s1_ts;
  assign opp_eff   = started ? opp_last_time : s1_ts;
  assign dwell_ok  = (s1_ts - entry_eff) >= min_dwell_ms;
  assign lat_mag   = pos_mag(s1_lat);
  assign sel_mag   = pos_mag(s1_sel);

  assign ahead = s1_seen && !s1_lon[POS_W-1] && (s1_lon != '0) &&
                 (s1_lon[DIST_W-1:0] <= follow_range) &&
                 (lat_mag <= {1'b0, corridor_half_width});

  // behind by more than the margin: lon + margin < 0
  assign lon_plus_margin = {s1_lon[POS_W-1], s1_lon} + {2'b00, behind_margin};
  assign passed = s1_seen && lon_plus_margin[POS_W];
  assign lost   = !s1_seen && ((s1_ts - opp_eff) >= LOST_TIMEOUT_MS);

  always_comb begin
    mode_next            = mode;
    side_next            = side;
    reason_next          = reason;
    started_next         = started;
    previous_time_next   = previous_time;
    mode_entry_time_next = mode_entry_time;
    opp_last_time_next   = opp_last_time;
    pending_valid_next   = pending_valid;
    pending_reason_next  = pending_reason;
    pending_start_next   = pending_start;
    hold_req             = 1'b0;
    hold_why             = RSN_NONE;
    hold_need            = transition_confirm_ms;
    go_mode              = mode;
    go_side              = SIDE_NONE;
    same_pend            = 1'b0;
    hold_done            = 1'b0;

    if (!terr) begin
      started_next         = 1'b1;
      previous_time_next   = s1_ts;
      mode_entry_time_next = entry_eff;
      opp_last_time_next   = s1_seen ? s1_ts : opp_eff;

      if (mode != MODE_INIT && mode != MODE_FAULT && (!s1_iok || !s1_pok)) begin
        mode_next            = MODE_FAULT;
        side_next            = SIDE_NONE;
        reason_next          = s1_iok ? RSN_INVALID_TRAJ : RSN_STALE_INPUT;
        mode_entry_time_next = s1_ts;
        pending_valid_next   = 1'b0;
        pending_reason_next  = RSN_NONE;
      end else begin
        unique case (mode)
          MODE_INIT: begin
            hold_need = recovery_confirm_ms;
            if (!s1_iok) begin
              reason_next         = RSN_WAIT_INPUTS;
              pending_valid_next  = 1'b0;
              pending_reason_next = RSN_NONE;
            end else if (!s1_pok) begin
              reason_next = RSN_WAIT_TRAJ;
              hold_req    = 1'b1;
              hold_why    = RSN_INIT_TRAJ_BAD;
              go_mode     = MODE_FAULT;
            end else begin
              hold_req = 1'b1;
              hold_why = RSN_INPUTS_READY;
              go_mode  = MODE_TRACK;
            end
          end
          MODE_TRACK: begin
            if (ahead && dwell_ok) begin
              hold_req = 1'b1;
              hold_why = RSN_OPP_AHEAD;
              go_mode  = MODE_TRAIL;
            end else begin
              pending_valid_next  = 1'b0;
              pending_reason_next = RSN_NONE;
            end
          end
          MODE_TRAIL: begin
            if (!ahead && dwell_ok) begin
              hold_req = 1'b1;
              hold_why = RSN_PATH_CLEAR;
              go_mode  = MODE_TRACK;
            end else if (dwell_ok && (sel_mag >= {1'b0, overtake_threshold})) begin
              hold_req = 1'b1;
              go_mode  = MODE_PASS;
              // positive offset is a pass on the left
              if (!s1_sel[POS_W-1] && (s1_sel != '0)) begin
                go_side  = SIDE_LEFT;
                hold_why = RSN_SAFE_LEFT;
              end else begin
                go_side  = SIDE_RIGHT;
                hold_why = RSN_SAFE_RIGHT;
              end
            end else begin
              pending_valid_next  = 1'b0;
              pending_reason_next = RSN_NONE;
            end
          end
          MODE_PASS: begin
            // before the dwell ends the pending move is left alone
            if (dwell_ok) begin
              if (passed || lost) begin
                hold_req = 1'b1;
                hold_why = passed ? RSN_OPP_BEHIND : RSN_OPP_LOST;
                go_mode  = MODE_RETURN;
              end else begin
                pending_valid_next  = 1'b0;
                pending_reason_next = RSN_NONE;
              end
            end
          end
          MODE_RETURN: begin
            if (dwell_ok && (sel_mag <= {1'b0, return_threshold}) && !ahead) begin
              hold_req = 1'b1;
              hold_why = RSN_RACELINE;
              go_mode  = MODE_TRACK;
            end else begin
              pending_valid_next  = 1'b0;
              pending_reason_next = RSN_NONE;
            end
          end
          MODE_FAULT: begin
            hold_need = recovery_confirm_ms;
            if (s1_iok && s1_pok) begin
              hold_req = 1'b1;
              hold_why = RSN_FAULT_RECOVERED;
              go_mode  = MODE_TRACK;
            end else begin
              pending_valid_next  = 1'b0;
              pending_reason_next = RSN_NONE;
            end
          end
          default: ;
        endcase

        if (hold_req) begin
          same_pend = pending_valid && (pending_reason == hold_why);
          // a freshly started hold has zero elapsed time
          hold_done = same_pend ? ((s1_ts - pending_start) >= hold_need)
                                : (hold_need == '0);
          pending_start_next = same_pend ? pending_start : s1_ts;
          if (hold_done) begin
            mode_next            = go_mode;
            side_next            = go_side;
            reason_next          = hold_why;
            mode_entry_time_next = s1_ts;
            pending_valid_next   = 1'b0;
            pending_reason_next  = RSN_NONE;
          end else begin
            pending_valid_next  = 1'b1;
            pending_reason_next = hold_why;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_INIT;
      side            <= SIDE_NONE;
      reason          <= RSN_NONE;
      started         <= 1'b0;
      previous_time   <= '0;
      mode_entry_time <= '0;
      opp_last_time   <= '0;
      pending_valid   <= 1'b0;
      pending_reason  <= RSN_NONE;
      pending_start   <= '0;
    end else if (proc) begin
      mode            <= mode_next;
      side            <= side_next;
      reason          <= reason_next;
      started         <= started_next;
      previous_time   <= previous_time_next;
      mode_entry_time <= mode_entry_time_next;
      opp_last_time   <= opp_last_time_next;
      pending_valid   <= pending_valid_next;
      pending_reason  <= pending_reason_next;
      pending_start   <= pending_start_next;
    end
  end

  // ---------------------------------------------------------------------------
  // command register
  logic [15:0] scale_next;
  logic        local_next;
  logic        fallback_next;

  always_comb begin
    scale_next    = '0;
    local_next    = 1'b0;
    fallback_next = 1'b0;
    unique case (mode_next)
      MODE_TRACK:  begin scale_next = CRUISE_SCALE; local_next = 1'b1; end
      MODE_TRAIL:  begin scale_next = TRAIL_SCALE;  local_next = 1'b1; end
      MODE_PASS:   begin scale_next = PASS_SCALE;   local_next = 1'b1; end
      MODE_RETURN: begin scale_next = RETURN_SCALE; local_next = 1'b1; end
      MODE_FAULT:  fallback_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      mode_out       <= mode_code(mode_next);
      side_out       <= side_next;
      reason_out     <= reason_next;
      speed_factor   <= scale_next;
      use_local_path <= local_next;
      use_fallback   <= fallback_next;
      time_error     <= terr;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions

  // a rejected beat leaves the supervisor state untouched
  a_terr_holds: assert property (@(posedge clk) disable iff (rst)
    proc && terr |=> $stable(mode) && $stable(previous_time) && $stable(pending_valid))
    else $error("backwards timestamp changed state");

  // any mode change clears the pending move
  a_change_drops: assert property (@(posedge clk) disable iff (rst)
    proc && (mode_next != mode) |=> !pending_valid)
    else $error("pending move survived a mode change");

  // fallback flag follows the fault mode on every command beat
  a_fallback: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (use_fallback == (mode_out == MODE_CODE_FAULT)))
    else $error("fallback flag disagrees with mode");

  // once started the timebase stays started
  a_started: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("started flag dropped");

  // a time error is only flagged against a history
  a_terr_needs_start: assert property (@(posedge clk) disable iff (rst)
    proc && !started |=> !time_error)
    else $error("time error on first beat");

endmodule

`default_nettype wire
